### design/apq_pkg.sv
// Shared types and codes for the array priority queue.
`timescale 1ns / 1ps
package apq_pkg;

  localparam int FIELD_VALUE_W  = 8;
  localparam int FIELD_PRIO_W   = 16;
  localparam int FIELD_COUNT_W  = 5;
  localparam int FIELD_STATUS_W = 2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  localparam logic [FIELD_STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [FIELD_STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [FIELD_STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic load;
    logic take;
  } cell_ctrl_t;

endpackage

### design/apq_cell.sv
// One storage cell of the queue: holds an entry, loads a new one or takes its neighbor's.
`timescale 1ns / 1ps
module apq_cell #(
  parameter int VALUE_BITS = 8
) (
  input  logic                                     clk,
  input  apq_pkg::cell_ctrl_t                      ctrl,
  input  logic [VALUE_BITS-1:0]                    load_value,
  input  logic signed [apq_pkg::FIELD_PRIO_W-1:0]  load_prio,
  input  logic [VALUE_BITS-1:0]                    next_value,
  input  logic signed [apq_pkg::FIELD_PRIO_W-1:0]  next_prio,
  output logic [VALUE_BITS-1:0]                    value,
  output logic signed [apq_pkg::FIELD_PRIO_W-1:0]  prio
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      value <= load_value;
      prio  <= load_prio;
    end else if (ctrl.take) begin
      value <= next_value;
      prio  <= next_prio;
    end
  end

endmodule

### design/array_priority_queue_top.sv
// Top level of the bounded max-priority queue built on a ring of cells.
// Insert, full insert and empty delete: result word in the cycle after acceptance, one per cycle while not stalled.
// Delete: a shift state closes the gap, then a scan state rotates the ring past a compare at cell 0
// to find the new top; a done state issues it once the result slot is free. Items stall until then.
// Reset clears the entry count and control; the cells are not cleared, and no clearing pass runs.
`timescale 1ns / 1ps
module array_priority_queue_top #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 8
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       item_valid,
  output logic                                       item_stall,
  input  logic                                       kind,
  input  logic [apq_pkg::FIELD_VALUE_W-1:0]          item_value,
  input  logic signed [apq_pkg::FIELD_PRIO_W-1:0]    item_priority,
  output logic                                       result_valid,
  input  logic                                       result_stall,
  output logic [apq_pkg::FIELD_STATUS_W-1:0]         status,
  output logic [apq_pkg::FIELD_VALUE_W-1:0]          removed_value,
  output logic signed [apq_pkg::FIELD_PRIO_W-1:0]    removed_priority,
  output logic                                       top_valid,
  output logic [apq_pkg::FIELD_VALUE_W-1:0]          top_value,
  output logic signed [apq_pkg::FIELD_PRIO_W-1:0]    top_priority,
  output logic [apq_pkg::FIELD_COUNT_W-1:0]          entry_count
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = apq_pkg::FIELD_PRIO_W;
  localparam int XW = (VALUE_BITS > apq_pkg::FIELD_VALUE_W) ? VALUE_BITS : apq_pkg::FIELD_VALUE_W;
  localparam int EW = (CW > apq_pkg::FIELD_COUNT_W) ? CW : apq_pkg::FIELD_COUNT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SHIFT = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]                  state;
  logic [CW-1:0]               count;
  logic [IW-1:0]               top_idx;
  logic [IW-1:0]               scan_idx;
  logic [VALUE_BITS-1:0]       top_val;
  logic signed [PW-1:0]        top_prio;
  logic [VALUE_BITS-1:0]       rem_val;
  logic signed [PW-1:0]        rem_prio;

  logic [apq_pkg::FIELD_STATUS_W-1:0] res_status;
  logic [VALUE_BITS-1:0]       res_rem_val;
  logic signed [PW-1:0]        res_rem_prio;
  logic                        res_top_valid;
  logic [VALUE_BITS-1:0]       res_top_val;
  logic signed [PW-1:0]        res_top_prio;
  logic [CW-1:0]               res_count;

  logic [VALUE_BITS-1:0]       cell_value [DEPTH];
  logic signed [PW-1:0]        cell_prio  [DEPTH];
  apq_pkg::cell_ctrl_t         cell_ctrl  [DEPTH];

  logic                        item_acc;
  logic                        res_free;
  logic                        is_full;
  logic                        is_empty;
  logic                        ins_ok;
  logic                        ins_top;
  logic                        scan_last;
  logic                        scan_hit;
  logic [XW-1:0]               item_x;
  logic [VALUE_BITS-1:0]       new_val;
  logic [XW-1:0]               rem_x;
  logic [XW-1:0]               top_x;
  logic [EW-1:0]               count_x;

  assign item_stall = (state != S_IDLE) || (result_valid && result_stall);
  assign item_acc   = item_valid && !item_stall;
  assign res_free   = !result_valid || !result_stall;
  assign is_full    = (count == CW'(DEPTH));
  assign is_empty   = (count == '0);
  assign item_x     = XW'(item_value);
  assign new_val    = item_x[VALUE_BITS-1:0];
  assign ins_ok     = item_acc && (kind == apq_pkg::KIND_INSERT) && !is_full;
  assign ins_top    = ins_ok && (is_empty || (item_priority > top_prio));
  assign scan_last  = (scan_idx == IW'(DEPTH - 1));
  assign scan_hit   = (state == S_SCAN) && (CW'(scan_idx) < count) &&
                      ((scan_idx == '0) || (cell_prio[0] > top_prio));

  // ring of cells; cell i takes from cell i+1, the last wraps to cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_ctrl[i].load = ins_ok && (count == CW'(i));
    assign cell_ctrl[i].take = ((state == S_SHIFT) && (IW'(i) >= top_idx)) ||
                               (state == S_SCAN);
    apq_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .load_value (new_val),
      .load_prio  (item_priority),
      .next_value (cell_value[(i + 1) % DEPTH]),
      .next_prio  (cell_prio[(i + 1) % DEPTH]),
      .value      (cell_value[i]),
      .prio       (cell_prio[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      scan_idx     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_acc) begin
            if (kind == apq_pkg::KIND_INSERT) begin
              res_rem_val   <= '0;
              res_rem_prio  <= '0;
              res_top_valid <= 1'b1;
              result_valid  <= 1'b1;
              if (is_full) begin
                res_status   <= apq_pkg::STATUS_FULL;
                res_top_val  <= top_val;
                res_top_prio <= top_prio;
                res_count    <= count;
              end else begin
                res_status   <= apq_pkg::STATUS_OK;
                count        <= count + 1'b1;
                res_count    <= count + 1'b1;
                res_top_val  <= ins_top ? new_val : top_val;
                res_top_prio <= ins_top ? item_priority : top_prio;
                if (ins_top) begin
                  top_val  <= new_val;
                  top_prio <= item_priority;
                  top_idx  <= count[IW-1:0];
                end
              end
            end else if (is_empty) begin
              res_status    <= apq_pkg::STATUS_EMPTY;
              res_rem_val   <= '0;
              res_rem_prio  <= '0;
              res_top_valid <= 1'b0;
              res_top_val   <= '0;
              res_top_prio  <= '0;
              res_count     <= '0;
              result_valid  <= 1'b1;
            end else begin
              rem_val  <= top_val;
              rem_prio <= top_prio;
              state    <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          count    <= count - 1'b1;
          scan_idx <= '0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_hit) begin
            top_val  <= cell_value[0];
            top_prio <= cell_prio[0];
            top_idx  <= scan_idx;
          end
          scan_idx <= scan_idx + 1'b1;
          if (scan_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_free) begin
            res_status    <= apq_pkg::STATUS_OK;
            res_rem_val   <= rem_val;
            res_rem_prio  <= rem_prio;
            res_top_valid <= !is_empty;
            res_top_val   <= is_empty ? '0 : top_val;
            res_top_prio  <= is_empty ? '0 : top_prio;
            res_count     <= count;
            result_valid  <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rem_x   = XW'(res_rem_val);
  assign top_x   = XW'(res_top_val);
  assign count_x = EW'(res_count);

  assign status           = res_status;
  assign removed_value    = rem_x[apq_pkg::FIELD_VALUE_W-1:0];
  assign removed_priority = res_rem_prio;
  assign top_valid        = res_top_valid;
  assign top_value        = top_x[apq_pkg::FIELD_VALUE_W-1:0];
  assign top_priority     = res_top_prio;
  assign entry_count      = count_x[apq_pkg::FIELD_COUNT_W-1:0];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    ins_ok |=> count == $past(count) + 1'b1)
    else $error("insert did not bump count");

  a_delete_start: assert property (@(posedge clk) disable iff (rst)
    (item_acc && (kind == apq_pkg::KIND_DELETE) && !is_empty) |=>
      (state == S_SHIFT) && !result_valid || (state == S_SHIFT))
    else $error("delete did not start gap close");

  a_scan_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && !scan_last |=> (state == S_SCAN) &&
      (scan_idx == $past(scan_idx) + 1'b1))
    else $error("scan step lost");

  a_result_top: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (res_top_valid == (res_count != '0)))
    else $error("top valid disagrees with count");

endmodule

### sim/array_priority_queue_top_tb.sv
// Self-checking testbench for the array priority queue: directed and random words.
`timescale 1ns / 1ps
module array_priority_queue_top_tb;

  localparam int QDEPTH     = 16;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_WAIT = QDEPTH + 8;

  typedef struct packed {
    logic [apq_pkg::FIELD_STATUS_W-1:0]       status;
    logic [apq_pkg::FIELD_VALUE_W-1:0]        removed_value;
    logic signed [apq_pkg::FIELD_PRIO_W-1:0]  removed_priority;
    logic                                     top_valid;
    logic [apq_pkg::FIELD_VALUE_W-1:0]        top_value;
    logic signed [apq_pkg::FIELD_PRIO_W-1:0]  top_priority;
    logic [apq_pkg::FIELD_COUNT_W-1:0]        entry_count;
  } queue_word_t;

  logic                                     clk = 1'b0;
  logic                                     rst = 1'b1;
  logic                                     item_valid = 1'b0;
  logic                                     item_stall;
  logic                                     kind = apq_pkg::KIND_INSERT;
  logic [apq_pkg::FIELD_VALUE_W-1:0]        item_value = '0;
  logic signed [apq_pkg::FIELD_PRIO_W-1:0]  item_priority = '0;
  logic                                     result_valid;
  logic                                     result_stall = 1'b0;
  logic [apq_pkg::FIELD_STATUS_W-1:0]       status;
  logic [apq_pkg::FIELD_VALUE_W-1:0]        removed_value;
  logic signed [apq_pkg::FIELD_PRIO_W-1:0]  removed_priority;
  logic                                     top_valid;
  logic [apq_pkg::FIELD_VALUE_W-1:0]        top_value;
  logic signed [apq_pkg::FIELD_PRIO_W-1:0]  top_priority;
  logic [apq_pkg::FIELD_COUNT_W-1:0]        entry_count;

  array_priority_queue_top dut (
    .clk, .rst, .item_valid, .item_stall, .kind, .item_value, .item_priority,
    .result_valid, .result_stall, .status, .removed_value, .removed_priority,
    .top_valid, .top_value, .top_priority, .entry_count
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow queue contents
  logic [apq_pkg::FIELD_VALUE_W-1:0]        shadow_value [QDEPTH];
  logic signed [apq_pkg::FIELD_PRIO_W-1:0]  shadow_prio  [QDEPTH];
  int                                       shadow_count = 0;

  queue_word_t expected_words [$];
  int error_count  = 0;
  int insert_count = 0;
  int delete_count = 0;
  int full_count   = 0;
  int empty_count  = 0;
  int checked_count = 0;
  bit no_idle = 1'b0;

  function automatic int shadow_top();
    int best;
    best = 0;
    for (int i = 1; i < shadow_count; i++)
      if (shadow_prio[i] > shadow_prio[best]) best = i;
    return best;
  endfunction

  task automatic predict_word(input logic k, input logic [apq_pkg::FIELD_VALUE_W-1:0] v,
                              input logic signed [apq_pkg::FIELD_PRIO_W-1:0] p);
    queue_word_t w;
    int t;
    w = '0;
    w.status = apq_pkg::STATUS_OK;
    if (k == apq_pkg::KIND_INSERT) begin
      insert_count++;
      if (shadow_count >= QDEPTH) begin
        w.status = apq_pkg::STATUS_FULL;
        full_count++;
      end else begin
        shadow_value[shadow_count] = v;
        shadow_prio[shadow_count]  = p;
        shadow_count++;
      end
    end else begin
      delete_count++;
      if (shadow_count == 0) begin
        w.status = apq_pkg::STATUS_EMPTY;
        empty_count++;
      end else begin
        t = shadow_top();
        w.removed_value    = shadow_value[t];
        w.removed_priority = shadow_prio[t];
        for (int i = t; i + 1 < shadow_count; i++) begin
          shadow_value[i] = shadow_value[i+1];
          shadow_prio[i]  = shadow_prio[i+1];
        end
        shadow_count--;
      end
    end
    if (shadow_count > 0) begin
      t = shadow_top();
      w.top_valid    = 1'b1;
      w.top_value    = shadow_value[t];
      w.top_priority = shadow_prio[t];
    end
    w.entry_count = shadow_count[apq_pkg::FIELD_COUNT_W-1:0];
    expected_words.push_back(w);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // caller is at a rising edge
  task automatic send_word(input logic k, input logic [apq_pkg::FIELD_VALUE_W-1:0] v,
                           input logic signed [apq_pkg::FIELD_PRIO_W-1:0] p);
    int gap;
    item_valid    <= 1'b1;
    kind          <= k;
    item_value    <= v;
    item_priority <= p;
    do @(posedge clk); while (item_stall);
    predict_word(k, v, p);
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [apq_pkg::FIELD_PRIO_W-1:0] pick_prio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return $signed(16'($urandom_range(0, 4)) - 16'sd2);
    if (r < 40) return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
    return $signed(16'($urandom));
  endfunction

  task automatic test_empty_delete();
    send_word(apq_pkg::KIND_DELETE, 8'hff, 16'sh7fff);
    send_word(apq_pkg::KIND_DELETE, 8'h00, 16'sh8000);
  endtask

  // fill to full with extremes and ties; top entry at index 0 and a twin at the last index
  task automatic test_fill_and_full();
    logic signed [apq_pkg::FIELD_PRIO_W-1:0] prios [QDEPTH] = '{
      16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1, 16'sd5, 16'sd5, 16'sd5, 16'sh8000,
      16'sh0001, 16'sh7ffe, 16'sd5, -16'sd1, 16'sh5555, -16'sh5556, 16'sh0000, 16'sh7fff
    };
    for (int i = 0; i < QDEPTH; i++)
      send_word(apq_pkg::KIND_INSERT, (i % 2 != 0) ? 8'(8'hff - i) : 8'(i), prios[i]);
    send_word(apq_pkg::KIND_INSERT, 8'haa, 16'sh7fff);
  endtask

  task automatic test_tie_deletes();
    repeat (4) send_word(apq_pkg::KIND_DELETE, 8'(255), 16'sh8000);
  endtask

  task automatic test_random_phase(input int n, input int insert_pct, input bit quiet);
    logic k;
    no_idle = quiet;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(0, 99) < insert_pct) ? apq_pkg::KIND_INSERT : apq_pkg::KIND_DELETE;
      send_word(k, 8'($urandom), pick_prio());
    end
    no_idle = 1'b0;
  endtask

  // result checker and receiver stall pattern
  int stall_hold = 0;
  always @(posedge clk) begin
    queue_word_t w;
    if (!rst && result_valid && !result_stall) begin
      checked_count++;
      if (expected_words.size() == 0) begin
        $error("result word with no expectation pending");
        error_count++;
      end else begin
        w = expected_words.pop_front();
        if (status !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, status); error_count++;
        end
        if (removed_value !== w.removed_value) begin
          $error("removed_value: expected %0d, got %0d", w.removed_value, removed_value);
          error_count++;
        end
        if (removed_priority !== w.removed_priority) begin
          $error("removed_priority: expected %0d, got %0d", w.removed_priority,
                 removed_priority);
          error_count++;
        end
        if (top_valid !== w.top_valid) begin
          $error("top_valid: expected %0d, got %0d", w.top_valid, top_valid); error_count++;
        end
        if (top_value !== w.top_value) begin
          $error("top_value: expected %0d, got %0d", w.top_value, top_value); error_count++;
        end
        if (top_priority !== w.top_priority) begin
          $error("top_priority: expected %0d, got %0d", w.top_priority, top_priority);
          error_count++;
        end
        if (entry_count !== w.entry_count) begin
          $error("entry_count: expected %0d, got %0d", w.entry_count, entry_count);
          error_count++;
        end
      end
    end
    if (no_idle) begin
      result_stall <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:59]: begin
          result_stall <= 1'b0;
          stall_hold = $urandom_range(0, 20);
        end
        [60:94]: begin
          result_stall <= 1'b1;
          stall_hold = $urandom_range(0, 2);
        end
        default: begin
          result_stall <= 1'b1;
          stall_hold = $urandom_range(10, 40);
        end
      endcase
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_delete();
    test_fill_and_full();
    test_tie_deletes();
    test_random_phase(100, 75, 1'b0);
    test_random_phase(100, 25, 1'b0);
    test_random_phase(60, 55, 1'b1);
    test_random_phase(140, 55, 1'b0);
    item_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d inserts (%0d full) and %0d deletes (%0d empty), %0d results checked",
             insert_count, full_count, delete_count, empty_count, checked_count);
    $display("errors: %0d", error_count);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
design/apq_pkg.sv
design/apq_cell.sv
design/array_priority_queue_top.sv
sim/array_priority_queue_top_tb.sv
